### src/imd_pkg.sv
package imd_pkg;

   // Default data width; the top level hands it down as the WIDTH parameter.
   localparam int DEF_WIDTH = 32;

   // Stored width of the post-shift register.
   localparam int POST_SHIFT_WIDTH = 7;

   // Stored width of the method flags register.
   localparam int FLAGS_WIDTH = 3;

   // Bit positions inside the method flags register.
   localparam int FLAG_POW2  = 0;
   localparam int FLAG_FIXUP = 1;
   localparam int FLAG_DNEG  = 2;

   // Width of the configuration register index.
   localparam int CSR_INDEX_WIDTH = 3;

   // Number of register stages in the datapath.
   localparam int NUM_STAGES = 7;

   // Stage numbers, counted from the input side starting at zero.
   localparam int ST_IN    = 0;
   localparam int ST_PP    = 1;
   localparam int ST_HIGH  = 2;
   localparam int ST_QABS  = 3;
   localparam int ST_QUOT  = 4;
   localparam int ST_RPP   = 5;
   localparam int ST_OUT   = 6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAGIC       = 3'd0,
      CSR_POST_SHIFT  = 3'd1,
      CSR_METHOD      = 3'd2,
      CSR_SIGNED_MODE = 3'd3,
      CSR_DIVISOR     = 3'd4
   } csr_index_type;

   // Per-stage load enables and valid bits of the pipeline.
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

endpackage

### src/imd_pipe_ctrl.sv
module imd_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output imd_pkg::pipe_ctrl_type ctrl
);

   logic [imd_pkg::NUM_STAGES-1:0] valid_ff;
   logic [imd_pkg::NUM_STAGES-1:0] valid_in;
   logic [imd_pkg::NUM_STAGES-1:0] load;

   // A stage loads when it is empty or when the stage after it moves on,
   // so bubbles collapse and a full stage never loses its transaction.
   always_comb begin
      load[imd_pkg::NUM_STAGES-1] = !valid_ff[imd_pkg::NUM_STAGES-1] || out_ready;
      for (int k = imd_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < imd_pkg::NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

endmodule

### src/imd_high_mult.sv
module imd_high_mult #(
   parameter int WIDTH = imd_pkg::DEF_WIDTH
) (
   input  logic             clock,
   input  logic             load_pp,
   input  logic             load_sum,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   output logic [WIDTH-1:0] high
);

   localparam int HW  = (WIDTH + 1) / 2;
   localparam int HIW = WIDTH - HW;
   localparam int LLW = 2 * HW;
   localparam int HHW = 2 * HIW;
   localparam int DW  = 2 * WIDTH;

   logic [HW-1:0]  xl, yl;
   logic [HIW-1:0] xh, yh;
   logic [LLW-1:0]   ll_ff, ll_in;
   logic [WIDTH-1:0] lh_ff, lh_in;
   logic [WIDTH-1:0] hl_ff, hl_in;
   logic [HHW-1:0]   hh_ff, hh_in;
   logic [DW-1:0]    full;
   logic [WIDTH-1:0] high_ff, high_in;

   assign xl = x[HW-1:0];
   assign xh = x[WIDTH-1:HW];
   assign yl = y[HW-1:0];
   assign yh = y[WIDTH-1:HW];

   // Four partial products of the half-word pieces of x and y.
   assign ll_in = LLW'(xl) * LLW'(yl);
   assign lh_in = WIDTH'(xl) * WIDTH'(yh);
   assign hl_in = WIDTH'(xh) * WIDTH'(yl);
   assign hh_in = HHW'(xh) * HHW'(yh);

   always_ff @(posedge clock) begin
      if (load_pp) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   assign full = DW'(ll_ff) + (DW'(lh_ff) << HW) + (DW'(hl_ff) << HW)
               + (DW'(hh_ff) << (2 * HW));
   assign high_in = full[DW-1:WIDTH];

   always_ff @(posedge clock) begin
      if (load_sum) begin
         high_ff <= high_in;
      end
   end

   assign high = high_ff;

endmodule

### src/imd_quot_sel.sv
module imd_quot_sel #(
   parameter int WIDTH = imd_pkg::DEF_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 load_abs,
   input  logic                                 load_sign,
   input  logic [WIDTH-1:0]                     mag,
   input  logic [WIDTH-1:0]                     high,
   input  logic                                 n_neg,
   input  logic [imd_pkg::POST_SHIFT_WIDTH-1:0] post_shift,
   input  logic [imd_pkg::FLAGS_WIDTH-1:0]      method_flags,
   input  logic                                 signed_mode,
   output logic [WIDTH-1:0]                     quotient
);

   localparam logic [imd_pkg::POST_SHIFT_WIDTH-1:0] WIDTH_S =
      imd_pkg::POST_SHIFT_WIDTH'(WIDTH);

   logic [imd_pkg::POST_SHIFT_WIDTH-1:0] fix_shift;
   logic [WIDTH-1:0] diff;
   logic [WIDTH-1:0] fix_sum;
   logic [WIDTH-1:0] q_abs_ff, q_abs_in;
   logic             neg_ff, neg_in;
   logic [WIDTH-1:0] quot_ff, quot_in;

   // Right shift that yields zero once the amount reaches the word width.
   function automatic logic [WIDTH-1:0] shr_sat(
      input logic [WIDTH-1:0]                     x,
      input logic [imd_pkg::POST_SHIFT_WIDTH-1:0] s
   );
      logic [WIDTH-1:0] r;
      if (s >= WIDTH_S) begin
         r = '0;
      end else begin
         r = x >> s;
      end
      return r;
   endfunction

   assign fix_shift = (post_shift == '0) ? '0 : post_shift - 1'b1;
   assign diff      = mag - high;
   assign fix_sum   = (diff >> 1) + high;

   // The power-of-two shortcut wins when both method bits are set.
   always_comb begin
      if (method_flags[imd_pkg::FLAG_POW2]) begin
         q_abs_in = shr_sat(mag, post_shift);
      end else if (method_flags[imd_pkg::FLAG_FIXUP]) begin
         q_abs_in = shr_sat(fix_sum, fix_shift);
      end else begin
         q_abs_in = shr_sat(high, post_shift);
      end
   end

   assign neg_in = signed_mode && (n_neg != method_flags[imd_pkg::FLAG_DNEG]);

   always_ff @(posedge clock) begin
      if (load_abs) begin
         q_abs_ff <= q_abs_in;
         neg_ff   <= neg_in;
      end
   end

   assign quot_in = neg_ff ? (WIDTH'(0) - q_abs_ff) : q_abs_ff;

   always_ff @(posedge clock) begin
      if (load_sign) begin
         quot_ff <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

### src/imd_rem_calc.sv
module imd_rem_calc #(
   parameter int WIDTH = imd_pkg::DEF_WIDTH
) (
   input  logic             clock,
   input  logic             load_pp,
   input  logic             load_out,
   input  logic [WIDTH-1:0] quot,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int HW  = (WIDTH + 1) / 2;
   localparam int HIW = WIDTH - HW;
   localparam int LLW = 2 * HW;

   logic [HW-1:0]    ql, dl;
   logic [HIW-1:0]   qh, dh;
   logic [LLW-1:0]   ll_ff, ll_in;
   logic [WIDTH-1:0] lh_ff, lh_in;
   logic [WIDTH-1:0] hl_ff, hl_in;
   logic [WIDTH-1:0] quot_ff;
   logic [WIDTH-1:0] dividend_ff;
   logic [WIDTH-1:0] product;
   logic [WIDTH-1:0] quotient_ff;
   logic [WIDTH-1:0] remainder_ff, remainder_in;

   assign ql = quot[HW-1:0];
   assign qh = quot[WIDTH-1:HW];
   assign dl = divisor[HW-1:0];
   assign dh = divisor[WIDTH-1:HW];

   // Only the low word of quotient times divisor is needed, so the
   // high-by-high partial product drops out.
   assign ll_in = LLW'(ql) * LLW'(dl);
   assign lh_in = WIDTH'(ql) * WIDTH'(dh);
   assign hl_in = WIDTH'(qh) * WIDTH'(dl);

   always_ff @(posedge clock) begin
      if (load_pp) begin
         ll_ff       <= ll_in;
         lh_ff       <= lh_in;
         hl_ff       <= hl_in;
         quot_ff     <= quot;
         dividend_ff <= dividend;
      end
   end

   assign product      = WIDTH'(ll_ff) + (lh_ff << HW) + (hl_ff << HW);
   assign remainder_in = dividend_ff - product;

   always_ff @(posedge clock) begin
      if (load_out) begin
         quotient_ff  <= quot_ff;
         remainder_ff <= remainder_in;
      end
   end

   assign quotient  = quotient_ff;
   assign remainder = remainder_ff;

endmodule

### src/invariant_divisor_magic_divide_core.sv
// Channel  Direction  Transaction content
// req_     in         dividend (WIDTH bits)
// rsp_     out        quotient, remainder (WIDTH bits each)
// csr_     in         register write: index and data, no handshake
//
// Every transaction passes seven register stages, from the edge that accepts
// the dividend to the one that raises rsp_tvalid; while rsp_tready is high,
// one dividend can enter each cycle. One stage captures the dividend and its
// magnitude, two go to each of the split multipliers (high half of magnitude
// times magic, low half of quotient times divisor), and two to method
// selection, post shift and sign correction. Reset is synchronous and active
// high; it empties the pipeline and loads the register defaults. A stall on
// rsp_ fills empty stages first, so req_tready stays high until every stage
// holds a transaction.
module invariant_divisor_magic_divide_core #(
   parameter int WIDTH = imd_pkg::DEF_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Bits from the lowest: dividend, then zero padding to whole bytes.
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0]     req_tdata,

   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Bits from the lowest: quotient, remainder, then zero padding.
   output logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,

   input  logic                                   csr_we,
   input  logic [imd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [WIDTH-1:0]                       csr_wdata
);

   localparam int RSP_W = ((2 * WIDTH + 7) / 8) * 8;

   // Configuration registers.
   logic [WIDTH-1:0]                     magic_ff;
   logic [imd_pkg::POST_SHIFT_WIDTH-1:0] post_shift_ff;
   logic [imd_pkg::FLAGS_WIDTH-1:0]      method_flags_ff;
   logic                                 signed_mode_ff;
   logic [WIDTH-1:0]                     divisor_ff;

   imd_pkg::pipe_ctrl_type ctrl;

   // Operand registers that travel beside the multiplier stages.
   logic [WIDTH-1:0] n_s0_ff, n_s0_in;
   logic [WIDTH-1:0] mag_s0_ff, mag_s0_in;
   logic             neg_s0_ff, neg_s0_in;
   logic [WIDTH-1:0] n_s1_ff, mag_s1_ff;
   logic             neg_s1_ff;
   logic [WIDTH-1:0] n_s2_ff, mag_s2_ff;
   logic             neg_s2_ff;
   logic [WIDTH-1:0] n_s3_ff, n_s4_ff;

   logic [WIDTH-1:0] high;
   logic [WIDTH-1:0] quot;
   logic [WIDTH-1:0] quotient;
   logic [WIDTH-1:0] remainder;

   // Register writes; an index outside the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff        <= '0;
         post_shift_ff   <= '0;
         method_flags_ff <= imd_pkg::FLAGS_WIDTH'(1);
         signed_mode_ff  <= 1'b0;
         divisor_ff      <= WIDTH'(1);
      end else if (csr_we) begin
         unique case (imd_pkg::csr_index_type'(csr_index))
            imd_pkg::CSR_MAGIC: begin
               magic_ff <= csr_wdata;
            end
            imd_pkg::CSR_POST_SHIFT: begin
               post_shift_ff <= csr_wdata[imd_pkg::POST_SHIFT_WIDTH-1:0];
            end
            imd_pkg::CSR_METHOD: begin
               method_flags_ff <= csr_wdata[imd_pkg::FLAGS_WIDTH-1:0];
            end
            imd_pkg::CSR_SIGNED_MODE: begin
               signed_mode_ff <= csr_wdata[0];
            end
            imd_pkg::CSR_DIVISOR: begin
               divisor_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   imd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   assign req_tready = ctrl.load[imd_pkg::ST_IN];
   assign rsp_tvalid = ctrl.valid[imd_pkg::ST_OUT];

   // Input stage: in signed mode a negative dividend is replaced by its
   // magnitude, and the most negative value maps to 2^(WIDTH-1).
   assign n_s0_in   = req_tdata[WIDTH-1:0];
   assign neg_s0_in = n_s0_in[WIDTH-1];
   assign mag_s0_in = (signed_mode_ff && neg_s0_in) ? (WIDTH'(0) - n_s0_in) : n_s0_in;

   always_ff @(posedge clock) begin
      if (ctrl.load[imd_pkg::ST_IN]) begin
         n_s0_ff   <= n_s0_in;
         mag_s0_ff <= mag_s0_in;
         neg_s0_ff <= neg_s0_in;
      end
      if (ctrl.load[imd_pkg::ST_PP]) begin
         n_s1_ff   <= n_s0_ff;
         mag_s1_ff <= mag_s0_ff;
         neg_s1_ff <= neg_s0_ff;
      end
      if (ctrl.load[imd_pkg::ST_HIGH]) begin
         n_s2_ff   <= n_s1_ff;
         mag_s2_ff <= mag_s1_ff;
         neg_s2_ff <= neg_s1_ff;
      end
      if (ctrl.load[imd_pkg::ST_QABS]) begin
         n_s3_ff <= n_s2_ff;
      end
      if (ctrl.load[imd_pkg::ST_QUOT]) begin
         n_s4_ff <= n_s3_ff;
      end
   end

   // High word of magnitude times magic.
   imd_high_mult #(
      .WIDTH (WIDTH)
   ) u_high_mult (
      .clock    (clock),
      .load_pp  (ctrl.load[imd_pkg::ST_PP]),
      .load_sum (ctrl.load[imd_pkg::ST_HIGH]),
      .x        (mag_s0_ff),
      .y        (magic_ff),
      .high     (high)
   );

   // Method selection, post shift and sign correction.
   imd_quot_sel #(
      .WIDTH (WIDTH)
   ) u_quot_sel (
      .clock        (clock),
      .load_abs     (ctrl.load[imd_pkg::ST_QABS]),
      .load_sign    (ctrl.load[imd_pkg::ST_QUOT]),
      .mag          (mag_s2_ff),
      .high         (high),
      .n_neg        (neg_s2_ff),
      .post_shift   (post_shift_ff),
      .method_flags (method_flags_ff),
      .signed_mode  (signed_mode_ff),
      .quotient     (quot)
   );

   // Remainder as dividend minus quotient times divisor, wrapping.
   imd_rem_calc #(
      .WIDTH (WIDTH)
   ) u_rem_calc (
      .clock     (clock),
      .load_pp   (ctrl.load[imd_pkg::ST_RPP]),
      .load_out  (ctrl.load[imd_pkg::ST_OUT]),
      .quot      (quot),
      .dividend  (n_s4_ff),
      .divisor   (divisor_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign rsp_tdata = RSP_W'({remainder, quotient});

endmodule

### tb/divide_result_checker.sv
`timescale 1ns / 100ps

module divide_result_checker #(
   parameter int WIDTH = imd_pkg::DEF_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0]     req_tdata,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                   csr_we,
   input  logic [imd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [WIDTH-1:0]                       csr_wdata,
   output int                                     error_count,
   output int                                     pending_count,
   output int                                     checked_count
);

   typedef struct {
      logic [WIDTH-1:0] dividend;
      logic [WIDTH-1:0] quotient;
      logic [WIDTH-1:0] remainder;
   } division_type;

   // Shadow copy of the block's registers, kept in step with the csr_ port.
   logic [WIDTH-1:0]                     magic_q   = '0;
   logic [imd_pkg::POST_SHIFT_WIDTH-1:0] shift_q   = '0;
   logic [imd_pkg::FLAGS_WIDTH-1:0]      flags_q   = imd_pkg::FLAGS_WIDTH'(1);
   logic                                 signed_q  = 1'b0;
   logic [WIDTH-1:0]                     divisor_q = WIDTH'(1);

   division_type pending_results[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
   end

   function automatic logic [WIDTH-1:0] shift_down(
      logic [WIDTH-1:0]                     x,
      logic [imd_pkg::POST_SHIFT_WIDTH-1:0] s
   );
      if (s >= WIDTH)
         return '0;
      return x >> s;
   endfunction

   // Quotient of a non-negative value by the configured method.
   function automatic logic [WIDTH-1:0] magnitude_quotient(logic [WIDTH-1:0] n);
      logic [2*WIDTH-1:0]                   product;
      logic [WIDTH-1:0]                     t;
      logic [WIDTH-1:0]                     diff;
      logic [WIDTH-1:0]                     sum;
      logic [imd_pkg::POST_SHIFT_WIDTH-1:0] s;
      if (flags_q[imd_pkg::FLAG_POW2])
         return shift_down(n, shift_q);
      product = {{WIDTH{1'b0}}, n} * {{WIDTH{1'b0}}, magic_q};
      t = product[2*WIDTH-1:WIDTH];
      if (flags_q[imd_pkg::FLAG_FIXUP]) begin
         s    = (shift_q == '0) ? '0 : shift_q - 1'b1;
         diff = n - t;
         sum  = (diff >> 1) + t;
         return shift_down(sum, s);
      end
      return shift_down(t, shift_q);
   endfunction

   function automatic division_type predict_division(logic [WIDTH-1:0] n);
      division_type     r;
      logic             n_neg;
      logic [WIDTH-1:0] mag;
      logic [WIDTH-1:0] q;
      r.dividend = n;
      if (signed_q) begin
         n_neg = n[WIDTH-1];
         mag   = n_neg ? '0 - n : n;
         q     = magnitude_quotient(mag);
         if (n_neg != flags_q[imd_pkg::FLAG_DNEG])
            q = '0 - q;
      end else begin
         q = magnitude_quotient(n);
      end
      r.quotient  = q;
      r.remainder = n - q * divisor_q;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      division_type     expected_div;
      logic [WIDTH-1:0] got_quotient;
      logic [WIDTH-1:0] got_remainder;
      got_quotient  = rsp_tdata[WIDTH-1:0];
      got_remainder = rsp_tdata[2*WIDTH-1:WIDTH];
      if (reset) begin
         magic_q   <= '0;
         shift_q   <= '0;
         flags_q   <= imd_pkg::FLAGS_WIDTH'(1);
         signed_q  <= 1'b0;
         divisor_q <= WIDTH'(1);
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing expected: quotient %h remainder %h",
                        $time, got_quotient, got_remainder);
               error_count++;
            end else begin
               expected_div = pending_results.pop_front();
               checked_count++;
               if (got_quotient !== expected_div.quotient) begin
                  $display("%0t: quotient of %h: expected %h, actual %h", $time,
                           expected_div.dividend, expected_div.quotient, got_quotient);
                  error_count++;
               end
               if (got_remainder !== expected_div.remainder) begin
                  $display("%0t: remainder of %h: expected %h, actual %h", $time,
                           expected_div.dividend, expected_div.remainder, got_remainder);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_division(req_tdata[WIDTH-1:0]));
         if (csr_we) begin
            case (csr_index)
               imd_pkg::CSR_MAGIC:       magic_q   <= csr_wdata;
               imd_pkg::CSR_POST_SHIFT:
                  shift_q <= csr_wdata[imd_pkg::POST_SHIFT_WIDTH-1:0];
               imd_pkg::CSR_METHOD:      flags_q   <= csr_wdata[imd_pkg::FLAGS_WIDTH-1:0];
               imd_pkg::CSR_SIGNED_MODE: signed_q  <= csr_wdata[0];
               imd_pkg::CSR_DIVISOR:     divisor_q <= csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = pending_results.size();
   end

endmodule

### tb/invariant_divisor_magic_divide_core_tb.sv
`timescale 1ns / 100ps

module invariant_divisor_magic_divide_core_tb;

   localparam int W        = imd_pkg::DEF_WIDTH;
   localparam int REQ_BITS = ((W + 7) / 8) * 8;
   localparam int RSP_BITS = ((2 * W + 7) / 8) * 8;

   // Dividends in the random part, the length of the one long output stall,
   // and the number of quiet cycles after which the run is declared hung.
   localparam int RANDOM_ITEMS    = 830;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Raw values for the five registers. Fields are kept 32 bits wide so that
   // a write can carry bits above the register's width, which must be dropped.
   typedef struct {
      logic [31:0] magic;
      logic [31:0] shift;
      logic [31:0] flags;
      logic [31:0] signed_mode;
      logic [31:0] divisor;
   } setting_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BITS-1:0]    req_tdata  = '0;   // dividend
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]    rsp_tdata;         // quotient, remainder
   logic                   csr_we     = 1'b0;
   imd_pkg::csr_index_type csr_index  = imd_pkg::CSR_MAGIC;
   logic [W-1:0]           csr_wdata  = '0;

   int error_count;
   int pending_count;
   int checked_count;

   // Mode flags shared with the output-side process; counters and divisor for the stimulus.
   bit          burst_mode       = 1'b0;
   bit          hold_off_request = 1'b0;
   int          sent_count       = 0;
   int          setting_count    = 0;
   int          pow2_settings    = 0;
   int          plain_settings   = 0;
   int          fixup_settings   = 0;
   logic [31:0] cur_divisor      = 1;

   invariant_divisor_magic_divide_core #(
      .WIDTH(W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   divide_result_checker #(
      .WIDTH(W)
   ) u_divide_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is held from the start of the run and then released on a falling edge,
   // once, at the start of the run.
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Index of the highest set bit; zero for an input of zero.
   function automatic int floor_log2(logic [31:0] x);
      int r;
      r = 0;
      for (int i = 0; i < 32; i++)
         if (x[i])
            r = i;
      return r;
   endfunction

   // Builds an exact setting for divisor pattern d, the way software would:
   // a plain shift for powers of two, otherwise the 33-bit magic with the
   // add fixup, whose low 32 bits go to the magic register. In signed mode
   // the magnitude of d is used and the negative flag carries its sign.
   function automatic setting_type divide_setting(logic [31:0] d, bit is_signed);
      setting_type s;
      logic [31:0] mag;
      logic [63:0] num;
      int          l;
      mag           = (is_signed && d[31]) ? 32'd0 - d : d;
      s.magic       = '0;
      s.flags       = '0;
      s.signed_mode = 32'(is_signed);
      s.divisor     = d;
      l             = floor_log2(mag);
      if ((mag & (mag - 32'd1)) == 32'd0) begin
         s.flags[imd_pkg::FLAG_POW2] = 1'b1;
         s.shift = l;
      end else begin
         l   = l + 1;
         num = ((64'd1 << l) - {32'd0, mag}) << 32;
         s.magic = 32'(num / {32'd0, mag} + 64'd1);
         s.flags[imd_pkg::FLAG_FIXUP] = 1'b1;
         s.shift = l;
      end
      if (is_signed && d[31])
         s.flags[imd_pkg::FLAG_DNEG] = 1'b1;
      return s;
   endfunction

   // Plain high-half multiply with a rounded-up 32-bit magic. It is not exact
   // for every divisor, which does not matter: the datapath is what is checked.
   // The divisor magnitude must be nonzero.
   function automatic setting_type plain_setting(logic [31:0] d, bit is_signed);
      setting_type s;
      logic [31:0] mag;
      int          l;
      mag           = (is_signed && d[31]) ? 32'd0 - d : d;
      l             = floor_log2(mag);
      s.magic       = 32'(((64'd1 << (32 + l)) / {32'd0, mag}) + 64'd1);
      s.shift       = l;
      s.flags       = '0;
      s.signed_mode = 32'(is_signed);
      s.divisor     = d;
      if (is_signed && d[31])
         s.flags[imd_pkg::FLAG_DNEG] = 1'b1;
      return s;
   endfunction

   // Mostly small divisors, with some large ones and powers of two. Never zero.
   function automatic logic [31:0] random_divisor();
      logic [31:0] d;
      case ($urandom_range(0, 3))
         0: d = $urandom_range(2, 20);
         1: d = $urandom_range(2, 100000);
         2: d = 32'd1 << $urandom_range(0, 31);
         default: d = $urandom;
      endcase
      if (d == 32'd0)
         d = 32'd1;
      return d;
   endfunction

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Draws one register setting of the given kind for the random part.
   function automatic setting_type random_setting(int kind);
      setting_type s;
      logic [31:0] d;
      bit          is_signed;
      is_signed = 1'($urandom_range(0, 1));
      d = random_divisor();
      if (is_signed && $urandom_range(0, 1))
         d = 32'd0 - d;
      case (kind)
         0: s = divide_setting(d, 1'b0);
         1: s = divide_setting(d, 1'b1);
         2: begin
            // Power-of-two shift with any amount, up to a full-width shift.
            s = divide_setting(d, is_signed);
            s.flags = '0;
            s.flags[imd_pkg::FLAG_POW2] = 1'b1;
            s.flags[imd_pkg::FLAG_FIXUP] = 1'($urandom_range(0, 1));
            s.flags[imd_pkg::FLAG_DNEG] = 1'($urandom_range(0, 1));
            s.shift = $urandom_range(0, 32);
            s.divisor = 32'd1 << ((s.shift < 32) ? s.shift : 0);
         end
         3: s = plain_setting(d, is_signed);
         4: begin
            // Arbitrary register contents, upper bits of the narrow
            // registers included; they must be dropped on the write.
            s.magic       = $urandom;
            s.shift       = $urandom;
            s.flags       = $urandom;
            s.signed_mode = $urandom;
            s.divisor     = $urandom;
         end
         default: begin
            s.magic       = corner_word();
            s.divisor     = corner_word();
            s.shift       = ($urandom_range(0, 1)) ? 32'd32 : $urandom_range(0, 1) * 31;
            s.flags       = $urandom_range(0, 7);
            s.signed_mode = 32'(is_signed);
         end
      endcase
      return s;
   endfunction

   // A dividend for the current divisor: corners, values around multiples of
   // the divisor (where truncation is most easily gotten wrong), small values
   // of either sign, and plain random words.
   function automatic logic [31:0] pick_dividend();
      logic [31:0] n;
      case ($urandom_range(0, 9))
         0: n = ($urandom_range(0, 5) == 0) ? 32'h8000_0001 : corner_word();
         1, 2: begin
            n = $urandom_range(0, 65535) * cur_divisor + $urandom_range(0, 2) - 32'd1;
            if ($urandom_range(0, 1))
               n = 32'd0 - n;
         end
         3: begin
            n = $urandom_range(0, 255);
            if ($urandom_range(0, 1))
               n = 32'd0 - n;
         end
         default: n = $urandom;
      endcase
      return n;
   endfunction

   // Offers one dividend and returns at the falling edge after its
   // transaction. Called and left at a falling edge; tvalid stays high when
   // the next dividend follows with no gap.
   task automatic send_dividend(input logic [31:0] value);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'(value);
      do
         @(posedge clock);
      while (!req_tready);
      sent_count++;
      @(negedge clock);
   endtask

   // Registers only change while the pipeline is empty: the input is
   // released, every expected result is awaited, then all five registers are
   // written on consecutive cycles.
   task automatic apply_setting(input setting_type s);
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= imd_pkg::CSR_MAGIC;
      csr_wdata <= W'(s.magic);
      @(negedge clock);
      csr_index <= imd_pkg::CSR_POST_SHIFT;
      csr_wdata <= W'(s.shift);
      @(negedge clock);
      csr_index <= imd_pkg::CSR_METHOD;
      csr_wdata <= W'(s.flags);
      @(negedge clock);
      csr_index <= imd_pkg::CSR_SIGNED_MODE;
      csr_wdata <= W'(s.signed_mode);
      @(negedge clock);
      csr_index <= imd_pkg::CSR_DIVISOR;
      csr_wdata <= W'(s.divisor);
      @(negedge clock);
      csr_we <= 1'b0;
      cur_divisor = (s.divisor == 32'd0) ? 32'd1 : s.divisor;
      setting_count++;
      if (s.flags[imd_pkg::FLAG_POW2])
         pow2_settings++;
      else if (s.flags[imd_pkg::FLAG_FIXUP])
         fixup_settings++;
      else
         plain_settings++;
   endtask

   // Output side: before each result it stalls at random, or not at all
   // in burst phases. Once, on request, it holds off for a long stretch so
   // that the pipeline fills and the input side is pushed back.
   initial begin : result_receiver
      int stall;
      bit held_off;
      held_off = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_off_request && !held_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held_off = 1'b1;
         end
         stall = burst_mode ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Hang detection: any cycle with a transaction on either channel or a
   // register write restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("invariant_divisor_magic_divide_core_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      setting_type s;
      int          random_sent;
      int          phase;
      int          items;
      int          kind;
      while (reset)
         @(negedge clock);

      // The registers still hold their reset values: a power-of-two shift by
      // zero in unsigned mode, so the quotient is the dividend itself.
      send_dividend(32'h0000_0000);
      send_dividend(32'hFFFF_FFFF);
      send_dividend(32'h8000_0000);

      // Exact unsigned division by seven through the add fixup.
      apply_setting(divide_setting(32'd7, 1'b0));
      send_dividend(32'h0000_0000);
      send_dividend(32'h0000_0006);
      send_dividend(32'h0000_0007);
      send_dividend(32'hFFFF_FFFF);

      // Signed division by minus three, including the most negative dividend.
      apply_setting(divide_setting(32'hFFFF_FFFD, 1'b1));
      send_dividend(32'h8000_0000);
      send_dividend(32'h7FFF_FFFF);
      send_dividend(32'hFFFF_FFFF);
      send_dividend(32'h0000_0005);

      // Both method bits set with a full-width shift: the shift wins and
      // gives zero.
      s.magic = 32'hFFFF_FFFF;
      s.shift = 32'd32;
      s.flags = '0;
      s.flags[imd_pkg::FLAG_POW2] = 1'b1;
      s.flags[imd_pkg::FLAG_FIXUP] = 1'b1;
      s.signed_mode = 32'd0;
      s.divisor = 32'd3;
      apply_setting(s);
      send_dividend(32'hFFFF_FFFF);
      send_dividend(32'h1234_5678);

      // Add fixup with a shift of zero, where the reduced shift stays at zero.
      s.shift = 32'd0;
      s.flags = '0;
      s.flags[imd_pkg::FLAG_FIXUP] = 1'b1;
      s.divisor = 32'hFFFF_FFFF;
      apply_setting(s);
      send_dividend(32'hFFFF_FFFF);
      send_dividend(32'h8000_0000);

      // Plain multiply in unsigned mode with the negative-divisor flag set,
      // which must be ignored. The writes carry junk above each narrow
      // register's width.
      s.magic = 32'hAAAA_AAAB;
      s.shift = 32'hABCD_EF85;
      s.flags = 32'hFFFF_FFF8;
      s.flags[imd_pkg::FLAG_DNEG] = 1'b1;
      s.signed_mode = 32'h0000_0002;
      s.divisor = 32'd3;
      apply_setting(s);
      send_dividend(32'hFFFF_FFFF);
      send_dividend(32'h0000_0005);

      // Signed divide by one: the most negative dividend's quotient wraps.
      apply_setting(divide_setting(32'd1, 1'b1));
      send_dividend(32'h8000_0000);
      send_dividend(32'h7FFF_FFFF);

      // Random part: a fresh setting per phase. Phase two is the one where
      // the output side holds off while dividends keep coming back to back.
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 5);
         apply_setting(random_setting(kind));
         items = $urandom_range(30, 70);
         burst_mode = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            burst_mode = 1'b1;
            hold_off_request = 1'b1;
            items = 60;
         end
         if (items > RANDOM_ITEMS - random_sent)
            items = RANDOM_ITEMS - random_sent;
         repeat (items) begin
            send_dividend(pick_dividend());
            random_sent++;
         end
         burst_mode = 1'b0;
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      // Let the pipeline drain so a stray extra result would still be seen.
      repeat (imd_pkg::NUM_STAGES + 3) @(negedge clock);

      $display("Sent %0d dividends under %0d register settings; %0d results checked.",
               sent_count, setting_count, checked_count);
      $display("Settings by method: %0d power-of-two, %0d plain multiply, %0d add fixup.",
               pow2_settings, plain_settings, fixup_settings);
      if (error_count == 0)
         $display("invariant_divisor_magic_divide_core_tb OK");
      else
         $display("invariant_divisor_magic_divide_core_tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
src/imd_pkg.sv
src/imd_pipe_ctrl.sv
src/imd_high_mult.sv
src/imd_quot_sel.sv
src/imd_rem_calc.sv
src/invariant_divisor_magic_divide_core.sv
tb/divide_result_checker.sv
tb/invariant_divisor_magic_divide_core_tb.sv
